// File: design/first_fit_cell_allocator_assert.svh
// ----------------------------------------------------------------------------
// First-fit cell allocator assertion macros
// Shorthand for clocked checks with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_CELL_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_CELL_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FFCA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFCA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Sizes, types and codes shared by the first-fit cell allocator modules.
// ----------------------------------------------------------------------------
package ffca_pkg;

    localparam int CELLS        = 1024;
    localparam int MAX_REQUESTS = 1024;

    localparam int FIELD_W    = 11;
    localparam int CELL_AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int REQ_AW     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CUR_W      = $clog2(CELLS + 1);
    localparam int SEQ_W      = $clog2(MAX_REQUESTS + 1);
    localparam int CMP_W      = (CUR_W > FIELD_W) ? CUR_W : FIELD_W;
    localparam int SEQ_CMP_W  = (SEQ_W > FIELD_W) ? SEQ_W : FIELD_W;
    localparam int ENT_W      = CELL_AW + FIELD_W;

    localparam int IN_DATA_W   = 2 * FIELD_W;
    localparam int IN_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((FIELD_W + 7) / 8) * 8;

    localparam logic [FIELD_W-1:0] CELLS_IN_USE_RST = FIELD_W'(1024);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_MARK,
        S_FREE_RD,
        S_FREE_CLR
    } t_state;

    typedef struct packed {
        logic               cell_we;
        logic               cell_wdata;
        logic [CELL_AW-1:0] cell_waddr;
        logic               cell_re;
        logic [CELL_AW-1:0] cell_raddr;
        logic               ent_we;
        logic [REQ_AW-1:0]  ent_waddr;
        logic [ENT_W-1:0]   ent_wdata;
        logic               ent_re;
        logic [REQ_AW-1:0]  ent_raddr;
    } t_mem_req;

    typedef struct packed {
        logic               load;
        logic               fits;
        logic [FIELD_W-1:0] start_position;
    } t_result;

endpackage

// File: design/ffca_ram.sv
// ----------------------------------------------------------------------------
// ffca_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/ffca_ctrl.sv
// ----------------------------------------------------------------------------
// ffca_ctrl
// Sequencer around one shared cell cursor: clear, scan, mark and release.
// ----------------------------------------------------------------------------
module ffca_ctrl
    import ffca_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_op,
    input  logic [FIELD_W-1:0] i_size,
    input  logic [FIELD_W-1:0] i_ref,
    output logic               o_ready,
    input  logic [CUR_W-1:0]   i_limit,
    input  logic               i_out_busy,
    input  logic               i_cell_rdata,
    input  logic [ENT_W-1:0]   i_ent_rdata,
    output t_mem_req           o_mem,
    output t_result            o_res
);

    t_state             r_state, n_state;
    logic [CUR_W-1:0]   r_cur, n_cur;
    logic               r_pend, n_pend;
    logic [CELL_AW-1:0] r_chk, n_chk;
    logic [CUR_W-1:0]   r_run, n_run;
    logic [CELL_AW-1:0] r_run_start, n_run_start;
    logic [FIELD_W-1:0] r_want, n_want;
    logic [FIELD_W-1:0] r_cnt, n_cnt;
    logic               r_fits, n_fits;
    logic [CELL_AW-1:0] r_start, n_start;
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic               r_ref_ok, n_ref_ok;

    logic [CUR_W-1:0]   w_run_inc;
    logic [CELL_AW-1:0] w_seg_start;
    logic               w_free;
    logic               w_hit;
    logic               w_more;
    logic               w_miss;
    logic               w_seq_full;
    logic               w_last;
    logic [CELL_AW-1:0] w_ent_start;
    logic [FIELD_W-1:0] w_ent_size;

    // shared cursor unit: run length, fit compare, end-of-range test
    assign w_run_inc   = r_run + CUR_W'(1);
    assign w_seg_start = (r_run == '0) ? r_chk : r_run_start;
    assign w_free      = r_pend && !i_cell_rdata;
    assign w_hit       = w_free && (CMP_W'(w_run_inc) >= CMP_W'(r_want));
    assign w_more      = r_cur < i_limit;
    assign w_miss      = !r_pend && !w_more;
    assign w_seq_full  = r_seq == SEQ_W'(MAX_REQUESTS);
    assign w_last      = (r_cnt == FIELD_W'(1)) || (r_cur == CUR_W'(CELLS - 1));
    assign w_ent_start = i_ent_rdata[CELL_AW-1:0];
    assign w_ent_size  = r_ref_ok ? i_ent_rdata[ENT_W-1:CELL_AW] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cur   <= '0;
            r_seq   <= '0;
        end else begin
            r_state <= n_state;
            r_cur   <= n_cur;
            r_seq   <= n_seq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend      <= n_pend;
        r_chk       <= n_chk;
        r_run       <= n_run;
        r_run_start <= n_run_start;
        r_want      <= n_want;
        r_cnt       <= n_cnt;
        r_fits      <= n_fits;
        r_start     <= n_start;
        r_ref_ok    <= n_ref_ok;
    end

    always_comb begin
        n_state     = r_state;
        n_cur       = r_cur;
        n_pend      = r_pend;
        n_chk       = r_chk;
        n_run       = r_run;
        n_run_start = r_run_start;
        n_want      = r_want;
        n_cnt       = r_cnt;
        n_fits      = r_fits;
        n_start     = r_start;
        n_seq       = r_seq;
        n_ref_ok    = r_ref_ok;
        o_ready     = 1'b0;
        o_mem       = '0;
        o_res       = '0;

        case (r_state)
            S_CLEAR: begin
                o_mem.cell_we    = 1'b1;
                o_mem.cell_wdata = 1'b0;
                o_mem.cell_waddr = r_cur[CELL_AW-1:0];
                n_cur            = r_cur + CUR_W'(1);
                if (r_cur == CUR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_op == OP_FREE) begin
                        o_mem.ent_re    = 1'b1;
                        o_mem.ent_raddr = REQ_AW'(i_ref - FIELD_W'(1));
                        n_ref_ok        = (i_ref != '0) &&
                                          (SEQ_CMP_W'(i_ref) <= SEQ_CMP_W'(r_seq));
                        n_state         = S_FREE_RD;
                    end else begin
                        n_want  = i_size;
                        n_cur   = '0;
                        n_run   = '0;
                        n_pend  = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read while the previous mark comes back
                o_mem.cell_re    = w_more;
                o_mem.cell_raddr = r_cur[CELL_AW-1:0];
                n_pend           = w_more;
                n_chk            = r_cur[CELL_AW-1:0];
                if (w_more) begin
                    n_cur = r_cur + CUR_W'(1);
                end
                if (r_pend) begin
                    if (!i_cell_rdata) begin
                        n_run       = w_run_inc;
                        n_run_start = w_seg_start;
                    end else begin
                        n_run = '0;
                    end
                end
                if (w_hit) begin
                    n_fits  = 1'b1;
                    n_start = w_seg_start;
                    n_state = S_EMIT;
                end else if (w_miss) begin
                    n_fits  = 1'b0;
                    n_start = '0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_out_busy) begin
                    o_res.load           = 1'b1;
                    o_res.fits           = r_fits;
                    o_res.start_position = r_fits ? FIELD_W'(r_start) + FIELD_W'(1) : '0;
                    o_mem.ent_we         = !w_seq_full;
                    o_mem.ent_waddr      = REQ_AW'(r_seq);
                    o_mem.ent_wdata      = {(r_fits ? r_want : FIELD_W'(0)), r_start};
                    if (!w_seq_full) begin
                        n_seq = r_seq + SEQ_W'(1);
                    end
                    if (r_fits && (r_want != '0)) begin
                        n_cur   = CUR_W'(r_start);
                        n_cnt   = r_want;
                        n_state = S_MARK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_MARK: begin
                o_mem.cell_we    = 1'b1;
                o_mem.cell_wdata = 1'b1;
                o_mem.cell_waddr = r_cur[CELL_AW-1:0];
                n_cur            = r_cur + CUR_W'(1);
                n_cnt            = r_cnt - FIELD_W'(1);
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            S_FREE_RD: begin
                // the free item takes its own entry, recorded empty
                o_mem.ent_we    = !w_seq_full;
                o_mem.ent_waddr = REQ_AW'(r_seq);
                o_mem.ent_wdata = '0;
                if (!w_seq_full) begin
                    n_seq = r_seq + SEQ_W'(1);
                end
                if ((w_ent_size == '0) || (CUR_W'(w_ent_start) >= CUR_W'(CELLS))) begin
                    n_state = S_IDLE;
                end else begin
                    n_cur   = CUR_W'(w_ent_start);
                    n_cnt   = w_ent_size;
                    n_state = S_FREE_CLR;
                end
            end
            S_FREE_CLR: begin
                o_mem.cell_we    = 1'b1;
                o_mem.cell_wdata = 1'b0;
                o_mem.cell_waddr = r_cur[CELL_AW-1:0];
                n_cur            = r_cur + CUR_W'(1);
                n_cnt            = r_cnt - FIELD_W'(1);
                if (w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/first_fit_cell_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_cell_allocator
// First-fit allocator over a row of cells with per-request bookkeeping.
// ----------------------------------------------------------------------------
// A row of CELLS cells carries one used mark each, kept in a one-bit RAM; a
// second RAM holds start and size for every request number. An allocate item
// (tuser 0) walks the marks from cell 0, one cell per cycle through a single
// cursor, and stops at the first free run long enough: the result gives fits
// and the 1-based start, then the cursor marks size cells used, one per cycle.
// A free item (tuser 1) looks up the named request and clears its cells, one
// per cycle, with no result. Both kinds of item are bound by the single
// cell-mark port. Input ready stays low while an item is at work; a finished
// result sits in the output register and the next item is taken meanwhile.
// After reset a clearing pass sweeps the marks of all CELLS cells before the
// first item is taken; configuration writes are taken at all times.
// Write cells_in_use only while the block is idle.
// ----------------------------------------------------------------------------
`include "first_fit_cell_allocator_assert.svh"

module first_fit_cell_allocator
    import ffca_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration: cells_in_use
    input  logic                   i_cfg_wr_en,
    input  logic [FIELD_W-1:0]     i_cfg_wr_data,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [10:0] size, [21:11] request_ref
    input  logic                   s_axis_tuser,   // [0] op
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [10:0] start_position
    output logic                   m_axis_tuser    // [0] fits
);

    logic [FIELD_W-1:0] r_cells_in_use;
    logic [CUR_W-1:0]   w_limit;

    logic               r_out_valid;
    logic               r_out_fits;
    logic [FIELD_W-1:0] r_out_pos;
    logic               w_out_busy;

    logic [FIELD_W-1:0] w_in_size;
    logic [FIELD_W-1:0] w_in_ref;

    logic               w_ready;
    t_mem_req           w_mem;
    t_result            w_res;
    logic               w_cell_rdata;
    logic [ENT_W-1:0]   w_ent_rdata;

    // Hold the cell count; clamp to the built row for the scan limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells_in_use <= CELLS_IN_USE_RST;
        end else if (i_cfg_wr_en) begin
            r_cells_in_use <= i_cfg_wr_data;
        end
    end

    assign w_limit = (CMP_W'(r_cells_in_use) > CMP_W'(CELLS)) ? CUR_W'(CELLS)
                                                              : CUR_W'(r_cells_in_use);

    // Unpack the input item.
    assign w_in_size = s_axis_tdata[FIELD_W-1:0];
    assign w_in_ref  = s_axis_tdata[2*FIELD_W-1:FIELD_W];

    assign s_axis_tready = w_ready;

    // Sequencer with the shared cell cursor.
    ffca_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_op         (s_axis_tuser),
        .i_size       (w_in_size),
        .i_ref        (w_in_ref),
        .o_ready      (w_ready),
        .i_limit      (w_limit),
        .i_out_busy   (w_out_busy),
        .i_cell_rdata (w_cell_rdata),
        .i_ent_rdata  (w_ent_rdata),
        .o_mem        (w_mem),
        .o_res        (w_res)
    );

    // Used mark per cell.
    ffca_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_cell_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.cell_we),
        .i_waddr (w_mem.cell_waddr),
        .i_wdata (w_mem.cell_wdata),
        .i_re    (w_mem.cell_re),
        .i_raddr (w_mem.cell_raddr),
        .o_rdata (w_cell_rdata)
    );

    // Start and size per request number; entries past the sequence count
    // are never trusted, so this RAM needs no clearing.
    ffca_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_REQUESTS)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.ent_we),
        .i_waddr (w_mem.ent_waddr),
        .i_wdata (w_mem.ent_wdata),
        .i_re    (w_mem.ent_re),
        .i_raddr (w_mem.ent_raddr),
        .o_rdata (w_ent_rdata)
    );

    // Output register: hold the result until taken, so the sequencer can
    // move on; the sequencer waits only when a second result would overrun.
    assign w_out_busy = r_out_valid && !m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.load) begin
            r_out_fits <= w_res.fits;
            r_out_pos  <= w_res.start_position;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_fits;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_pos);

    // Checks
    `FFCA_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "input ready while an item is at work")
    `FFCA_ASSERT_IMP(a_no_overrun, w_res.load, !w_out_busy,
        "result loaded over a pending result")
    `FFCA_ASSERT_IMP(a_fail_pos_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0,
        "failed allocation with nonzero start")
    `FFCA_ASSERT_IMP(a_fit_pos_nonzero, w_res.load && w_res.fits,
        w_res.start_position != '0, "successful allocation with zero start")

endmodule

// File: verif/first_fit_cell_allocator_test.sv
// ----------------------------------------------------------------------------
// first_fit_cell_allocator_test
// Self-checking bench for the first-fit cell allocator. It drives allocate
// and free items over the input stream and keeps its own model of the cell
// marks and the per-request ranges. Every result item is checked against the
// placement predicted for the oldest outstanding allocate. The cell count is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module first_fit_cell_allocator_test
    import ffca_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Longest stretch without any handshake before the run is declared hung.
    // It is set to outlast a worst-case item, the pause around a cell count
    // change and the receiver hold-off.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 3000;
    localparam int SETTLE_CYCLES  = 2 * CELLS + 8;
    localparam int MAX_GAP        = 40;

    // One expected result item.
    typedef struct packed {
        logic               fits;
        logic [FIELD_W-1:0] start_position;
    } t_placement;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the cell marks and request records, plus the
    // queue of placements still owed by the block.
    // ------------------------------------------------------------------------
    class placement_scoreboard;
        bit               cell_used   [CELLS];
        bit [CELL_AW-1:0] entry_start [MAX_REQUESTS];
        bit [FIELD_W-1:0] entry_size  [MAX_REQUESTS];
        int unsigned      seq_count;
        bit [FIELD_W-1:0] cells_cfg;
        t_placement       placements_due [$];
        int unsigned      live_refs [$];
        int unsigned      mismatches;

        function new();
            foreach (cell_used[i]) cell_used[i] = 1'b0;
            foreach (entry_size[i]) begin
                entry_start[i] = '0;
                entry_size[i]  = '0;
            end
            seq_count  = 0;
            cells_cfg  = CELLS_IN_USE_RST;
            mismatches = 0;
        endfunction

        // Record a range under the next request number; returns that number,
        // or 0 once the numbers are used up.
        function int unsigned log_entry(int unsigned start, int unsigned size);
            if (seq_count < MAX_REQUESTS) begin
                entry_start[seq_count] = CELL_AW'(start);
                entry_size[seq_count]  = FIELD_W'(size);
                seq_count++;
                return seq_count;
            end
            return 0;
        endfunction

        // Advance the model by one accepted input item.
        function void note_item(logic op, logic [FIELD_W-1:0] size,
                                logic [FIELD_W-1:0] req_ref);
            int unsigned lim;
            int unsigned j;
            int unsigned first;
            int unsigned run;
            int unsigned seq;
            bit          found;
            t_placement  due;
            lim = (cells_cfg > CELLS) ? CELLS : cells_cfg;
            if (op == OP_FREE) begin
                if (req_ref >= 1 && req_ref <= MAX_REQUESTS) begin
                    for (int k = 0; k < entry_size[req_ref-1]; k++) begin
                        if (entry_start[req_ref-1] + k >= CELLS) break;
                        cell_used[entry_start[req_ref-1] + k] = 1'b0;
                    end
                    for (int i = live_refs.size() - 1; i >= 0; i--) begin
                        if (live_refs[i] == req_ref) live_refs.delete(i);
                    end
                end
                void'(log_entry(0, 0));
                return;
            end
            // First fit: stop at the first maximal free run long enough.
            found = 1'b0;
            first = 0;
            j     = 0;
            while (j < lim && !found) begin
                if (cell_used[j]) begin
                    j++;
                end else begin
                    first = j;
                    run   = 0;
                    while (j < lim && !cell_used[j]) begin
                        run++;
                        j++;
                    end
                    found = (run >= size);
                end
            end
            if (found) begin
                for (int k = 0; k < size; k++) begin
                    if (first + k >= CELLS) break;
                    cell_used[first + k] = 1'b1;
                end
                seq = log_entry(first, size);
                if (seq != 0 && size != 0) live_refs.push_back(seq);
                due.fits           = 1'b1;
                due.start_position = FIELD_W'(first + 1);
            end else begin
                void'(log_entry(0, 0));
                due = '0;
            end
            placements_due.push_back(due);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic fits, logic [FIELD_W-1:0] start_position);
            t_placement due;
            if (placements_due.size() == 0) begin
                report($sformatf("result with none outstanding: fits=%0b start=%0d",
                                 fits, start_position));
                return;
            end
            due = placements_due.pop_front();
            if (fits !== due.fits)
                report($sformatf("fits %0b, predicted %0b", fits, due.fits));
            if (start_position !== due.start_position)
                report($sformatf("start_position %0d, predicted %0d",
                                 start_position, due.start_position));
        endtask

        task check_drained();
            if (placements_due.size() != 0)
                report($sformatf("%0d results never arrived", placements_due.size()));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_wr_en   = 1'b0;
    logic [FIELD_W-1:0]     i_cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;   // [10:0] size, [21:11] request_ref
    logic                   s_axis_tuser  = 1'b0; // [0] op
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;         // [10:0] start_position
    logic                   m_axis_tuser;         // [0] fits

    first_fit_cell_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    placement_scoreboard sb;

    int unsigned send_idle_pct  = 0;   // chance per cycle of a gap before an item
    int unsigned recv_stall_pct = 0;   // chance per cycle of tready low
    logic        hold_off       = 1'b0; // long receiver hold-off in progress
    int unsigned idle_cycles    = 0;

    // Receiver: stall at random, or hold off completely while hold_off is set.
    always @(posedge i_clk) begin
        m_axis_tready <= hold_off ? 1'b0 : ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Result monitor and watchdog. Values read here are the ones that were
    // stable before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tuser, m_axis_tdata[FIELD_W-1:0]);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("first_fit_cell_allocator regression: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers. All are called at a rising edge and return at one.
    // ------------------------------------------------------------------------

    // Offer one item, optionally after a random gap, and hold it until the
    // block takes it; then note it in the scoreboard. tvalid is left high so
    // that back-to-back items need no second assignment in one step.
    task automatic send_item(input logic op, input logic [FIELD_W-1:0] size,
                             input logic [FIELD_W-1:0] req_ref);
        int unsigned gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_TDATA_W'({req_ref, size});
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_item(op, size, req_ref);
    endtask

    // Drain outstanding results, let any free still at work finish, then
    // write the cell count.
    task automatic set_cell_count(input logic [FIELD_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (sb.placements_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.cells_cfg   = value;
    endtask

    // Random traffic. Mostly allocate/free pairs: frees favor ranges that are
    // still held, some hit any recorded request, a few are out of range.
    // Frees never name a request number that has not been recorded yet.
    task automatic run_random(input int unsigned count);
        int unsigned lim;
        int unsigned span;
        int unsigned sel;
        int unsigned top;
        logic        op;
        logic [FIELD_W-1:0] size;
        logic [FIELD_W-1:0] req_ref;
        repeat (count) begin
            lim  = (sb.cells_cfg > CELLS) ? CELLS : sb.cells_cfg;
            span = (lim != 0) ? lim : 4;
            size    = FIELD_W'($urandom);
            req_ref = FIELD_W'($urandom);
            if ($urandom_range(0, 99) < 55 || sb.seq_count == 0) begin
                op  = OP_ALLOC;
                sel = $urandom_range(0, 99);
                if (sel < 65)      size = FIELD_W'($urandom_range(0, (span + 3) / 4));
                else if (sel < 85) size = FIELD_W'($urandom_range(0, span));
                else if (sel < 92) size = '0;
                else               size = FIELD_W'($urandom_range(MAX_REQUESTS + 1, 2047));
            end else begin
                op  = OP_FREE;
                sel = $urandom_range(0, 99);
                top = (sb.seq_count < MAX_REQUESTS) ? sb.seq_count : MAX_REQUESTS;
                if (sel < 75 && sb.live_refs.size() != 0)
                    req_ref = FIELD_W'(sb.live_refs[$urandom_range(0, sb.live_refs.size() - 1)]);
                else if (sel < 90)
                    req_ref = FIELD_W'($urandom_range(1, top));
                else if ($urandom_range(0, 1) == 0)
                    req_ref = '0;
                else
                    req_ref = FIELD_W'($urandom_range(MAX_REQUESTS + 1, 2047));
            end
            send_item(op, size, req_ref);
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part on an 8-cell row; the pause in set_cell_count also
        // covers the clearing pass after reset. Unused fields carry noise.
        set_cell_count(11'd8);
        send_item(OP_ALLOC, 11'd0,    FIELD_W'($urandom)); // zero size: first free cell
        send_item(OP_ALLOC, 11'd3,    FIELD_W'($urandom)); // cells 0..2
        send_item(OP_ALLOC, 11'd5,    FIELD_W'($urandom)); // cells 3..7, row full
        send_item(OP_ALLOC, 11'd0,    FIELD_W'($urandom)); // no free cell: zero size fails
        send_item(OP_ALLOC, 11'd1,    FIELD_W'($urandom)); // no free cell
        send_item(OP_FREE,  FIELD_W'($urandom), 11'd4);    // failed request: no effect
        send_item(OP_FREE,  FIELD_W'($urandom), 11'd2);    // release cells 0..2
        send_item(OP_ALLOC, 11'd2,    FIELD_W'($urandom)); // cells 0..1
        send_item(OP_FREE,  FIELD_W'($urandom), 11'd2);    // repeat free clears 0..2 again
        send_item(OP_ALLOC, 11'd3,    FIELD_W'($urandom)); // cells 0..2
        send_item(OP_FREE,  FIELD_W'($urandom), 11'd0);    // reference zero
        send_item(OP_FREE,  FIELD_W'($urandom), 11'd2047); // reference far out of range
        send_item(OP_FREE,  FIELD_W'($urandom), 11'd1025); // just past the last request
        send_item(OP_ALLOC, 11'd2047, FIELD_W'($urandom)); // largest size
        send_item(OP_ALLOC, 11'd1024, FIELD_W'($urandom)); // full-row size on a short row
        send_item(OP_FREE,  FIELD_W'($urandom), 11'd6);    // a free item's own record
        send_item(OP_FREE,  FIELD_W'($urandom), 11'd3);    // release cells 3..7
        send_item(OP_ALLOC, 11'd2,    FIELD_W'($urandom)); // cells 3..4
        send_item(OP_FREE,  FIELD_W'($urandom), 11'd10);   // release cells 0..2
        send_item(OP_ALLOC, 11'd1,    FIELD_W'($urandom)); // cell 0, leaves a 2-cell hole
        send_item(OP_ALLOC, 11'd3,    FIELD_W'($urandom)); // skip the hole: cells 5..7
        set_cell_count(11'd1024);
        send_item(OP_ALLOC, 11'd1016, FIELD_W'($urandom)); // skip the hole: cells 8..1023
        send_item(OP_ALLOC, 11'd2,    FIELD_W'($urandom)); // fill the hole
        send_item(OP_FREE,  FIELD_W'($urandom), 11'd22);   // release the big range
        set_cell_count(11'd0);
        send_item(OP_ALLOC, 11'd0,    FIELD_W'($urandom)); // no cell scanned: fails

        // Random phases over several row lengths and idling patterns.
        set_cell_count(11'd1024);
        send_idle_pct = 0;  recv_stall_pct <= 0;
        run_random(60);

        set_cell_count(11'd48);
        send_idle_pct = 79; recv_stall_pct <= 0;
        run_random(100);

        set_cell_count(11'd16);
        send_idle_pct = 0;  recv_stall_pct <= 79;
        run_random(100);

        set_cell_count(11'd2047);  // above the row length: taken as the full row
        send_idle_pct = 26; recv_stall_pct <= 26;
        run_random(60);

        // Hold the receiver off for a long stretch while items keep coming,
        // so the result register fills and the input stalls.
        set_cell_count(11'd100);
        send_idle_pct = 0;  recv_stall_pct <= 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
            run_random(100);
        join

        set_cell_count(11'd1);
        send_idle_pct = 0;  recv_stall_pct <= 79;
        run_random(40);

        set_cell_count(11'd0);
        send_idle_pct = 79; recv_stall_pct <= 0;
        run_random(20);

        set_cell_count(11'd300);
        send_idle_pct = 26; recv_stall_pct <= 26;
        run_random(35);

        // Short row with many small items.
        set_cell_count(11'd32);
        run_random(40);

        // Drain and settle, then give the verdict.
        s_axis_tvalid <= 1'b0;
        while (sb.placements_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.mismatches == 0)
            $display("first_fit_cell_allocator regression: pass");
        else
            $display("first_fit_cell_allocator regression: fail");
        $finish;
    end

endmodule
